>>> rtl/pfs_pkg.sv
// Shared types, codes and defaults of the periodic frame scheduler.
package pfs_pkg;

  localparam int MAX_ENTRIES_DEF = 16;
  localparam int TX_SLOTS_DEF    = 3;
  localparam logic [7:0] FAIL_LIMIT_RST = 8'd3;

  // input item kinds
  localparam logic [1:0] KIND_ADD    = 2'd0;
  localparam logic [1:0] KIND_REMOVE = 2'd1;
  localparam logic [1:0] KIND_PASS   = 2'd2;

  // status codes
  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_FULL      = 3'd1;
  localparam logic [2:0] ST_ZERO_PER  = 3'd2;
  localparam logic [2:0] ST_DUP       = 3'd3;
  localparam logic [2:0] ST_NOT_FOUND = 3'd4;

  // register index of fail_limit
  localparam logic REG_FAIL_LIMIT = 1'b0;

  typedef struct packed {
    logic [28:0] id;
    logic        fmt;
    logic [15:0] period;
    logic [31:0] last_tick;
    logic [31:0] missed;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  typedef struct packed {
    logic        kind;
    logic [2:0]  status;
    logic [3:0]  index;
    logic [28:0] id;
    logic        ext;
    logic        sent;
    logic        abort;
    logic        last;
  } res_t;

  function automatic res_t mk_status(input logic [2:0] code);
    res_t r;
    r = '0;
    r.status = code;
    r.last = 1'b1;
    return r;
  endfunction

endpackage

>>> rtl/pfs_ram.sv
// Generic single-write, single-read RAM with registered read data.
module pfs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                  clk,
  input  logic                                  we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                      wdata,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                      rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> rtl/pfs_div.sv
// Restoring divider, 32-bit dividend by 16-bit divisor, one quotient bit a cycle.
module pfs_div (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [31:0] dividend,
  input  logic [15:0] divisor,
  output logic        done,
  output logic [31:0] quotient
);

  logic [15:0] rem;
  logic [31:0] dq;
  logic [15:0] dvs;
  logic [5:0]  cnt;
  logic        busy;
  logic [16:0] rem_sh;
  logic        ge;

  assign rem_sh = {rem, dq[31]};
  assign ge = rem_sh >= {1'b0, dvs};
  assign quotient = dq;

  // shift/subtract step
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt <= '0;
        rem <= '0;
        dq <= dividend;
        dvs <= divisor;
      end else if (busy) begin
        rem <= ge ? 16'(rem_sh - {1'b0, dvs}) : rem_sh[15:0];
        dq <= {dq[30:0], ge};
        cnt <= cnt + 6'd1;
        if (cnt == 6'd31) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

>>> rtl/periodic_frame_scheduler_core.sv
// Top level of the periodic frame scheduler: table sequencer, config port, output stage.
//
//  channel | direction | handshake          | payload
//  cfg     | in/out    | psel/penable/pready| paddr, pwdata, prdata (fail_limit)
//  in      | in        | in_valid/in_stall  | kind, frame_id, extended, period_ms, now_tick,
//          |           |                    | free_slots
//  out     | out       | out_valid/out_stall| result_kind, status, entry_index, out_id,
//          |           |                    | out_extended, sent, abort_all, last
//
// One item at a time. Add/remove scan the table entry by entry through the registered RAM
// read; remove then shifts each later entry down by one (read, then write). A pass checks
// each entry, sends a due entry while slots remain and defers it through the serial divider.
// Results leave through one output register and a held result that carries the last flag;
// a stalled output holds the sequencer. Synchronous reset clears the count, fail_limit and control; no clearing pass.
module periodic_frame_scheduler_core #(
  parameter int MAX_ENTRIES = pfs_pkg::MAX_ENTRIES_DEF,
  parameter int TX_SLOTS    = pfs_pkg::TX_SLOTS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  kind,
  input  logic [28:0] frame_id,
  input  logic        extended,
  input  logic [15:0] period_ms,
  input  logic [31:0] now_tick,
  input  logic [1:0]  free_slots,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        result_kind,
  output logic [2:0]  status,
  output logic [3:0]  entry_index,
  output logic [28:0] out_id,
  output logic        out_extended,
  output logic        sent,
  output logic        abort_all,
  output logic        last
);

  import pfs_pkg::*;

  localparam int IW = MAX_ENTRIES > 1 ? $clog2(MAX_ENTRIES) : 1;
  localparam int CW = $clog2(MAX_ENTRIES + 1);
  localparam int SW = $clog2(TX_SLOTS + 1);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_RD    = 4'd1;
  localparam logic [3:0] S_CHK   = 4'd2;
  localparam logic [3:0] S_SEND  = 4'd3;
  localparam logic [3:0] S_DIV   = 4'd4;
  localparam logic [3:0] S_DEFER = 4'd5;
  localparam logic [3:0] S_PUSH  = 4'd6;
  localparam logic [3:0] S_SHRD  = 4'd7;
  localparam logic [3:0] S_SHWR  = 4'd8;
  localparam logic [3:0] S_ADDWR = 4'd9;
  localparam logic [3:0] S_FIN   = 4'd10;

  logic [3:0]    state;
  logic [7:0]    fail_limit;
  logic [CW-1:0] entry_count;
  logic [CW-1:0] idx;
  logic [SW-1:0] slots;
  logic [1:0]    op;
  logic [28:0]   id_r;
  logic          ext_r;
  logic [15:0]   per_r;
  logic [31:0]   now_r;
  entry_t        ent;
  logic [31:0]   elapsed;
  res_t          res;
  res_t          pend;
  logic          pend_valid;
  res_t          out_r;
  res_t          rep;
  res_t          pend_last;
  logic          out_load;

  logic          ram_we;
  logic [IW-1:0] ram_waddr;
  entry_t        ram_wdata;
  logic [IW-1:0] ram_raddr;
  entry_t        ram_rdata;
  logic [ENTRY_W-1:0] ram_rbits;

  logic          div_start;
  logic          div_done;
  logic [31:0]   div_q;

  logic          in_acc;
  logic          out_free;
  logic [31:0]   el_now;
  logic          due;
  logic [31:0]   el_left;
  logic [IW+3:0] ix_w;
  logic [CW:0]   idx_p1;
  logic [CW:0]   idx_p2;
  logic [CW:0]   cnt_x;

  assign in_stall = state != S_IDLE;
  assign in_acc   = in_valid && !in_stall;
  assign out_free = !out_valid || !out_stall;
  assign pready   = 1'b1;
  assign prdata   = (paddr[2] == REG_FAIL_LIMIT) ? {24'b0, fail_limit} : 32'b0;

  assign el_now  = now_r - ram_rdata.last_tick;
  assign due     = (ram_rdata.period != 16'd0) && (el_now >= {16'b0, ram_rdata.period});
  assign el_left = elapsed - {16'b0, ent.period};
  assign ix_w    = {4'b0, idx[IW-1:0]};
  assign idx_p1  = {1'b0, idx} + 1'b1;
  assign idx_p2  = {1'b0, idx} + 2'd2;
  assign cnt_x   = {1'b0, entry_count};

  assign ram_rdata = entry_t'(ram_rbits);
  assign ram_raddr = (state == S_SHRD) ? idx_p1[IW-1:0] : idx[IW-1:0];
  assign div_start = (state == S_CHK) && (op == KIND_PASS) && due && (slots == '0);

  // due entry report for the entry being handled
  always_comb begin
    rep = '0;
    rep.kind = 1'b1;
    rep.index = ix_w[3:0];
    rep.id = ent.id;
    rep.ext = ent.fmt;
    rep.sent = state == S_SEND;
    rep.abort = (state == S_DEFER) && (div_q > ent.missed) && (fail_limit != 8'd0)
                && (div_q >= {24'b0, fail_limit});
  end

  // held result closing the item carries the last flag
  always_comb begin
    pend_last = pend;
    pend_last.last = 1'b1;
  end

  assign out_load = pend_valid && out_free && (state == S_PUSH || state == S_FIN);

  // table writes: append, shift down, send update, deferral update
  always_comb begin
    ram_we = 1'b0;
    ram_waddr = idx[IW-1:0];
    ram_wdata = ent;
    case (state)
      S_ADDWR: begin
        ram_we = 1'b1;
        ram_waddr = entry_count[IW-1:0];
        ram_wdata.id = id_r;
        ram_wdata.fmt = ext_r;
        ram_wdata.period = per_r;
        ram_wdata.last_tick = now_r;
        ram_wdata.missed = '0;
      end
      S_SHWR: begin
        ram_we = 1'b1;
        ram_wdata = ram_rdata;
      end
      S_SEND: begin
        ram_we = 1'b1;
        ram_wdata.missed = '0;
        ram_wdata.last_tick = (el_left >= {16'b0, ent.period}) ? now_r
                              : ent.last_tick + {16'b0, ent.period};
      end
      S_DEFER: begin
        ram_we = div_q > ent.missed;
        ram_wdata.missed = div_q;
      end
      default: ;
    endcase
  end

  pfs_ram #(.WIDTH(ENTRY_W), .DEPTH(MAX_ENTRIES)) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rbits)
  );

  pfs_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (el_now),
    .divisor  (ram_rdata.period),
    .done     (div_done),
    .quotient (div_q)
  );

  // configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      fail_limit <= FAIL_LIMIT_RST;
    end else if (psel && penable && pwrite && pready && paddr[2] == REG_FAIL_LIMIT) begin
      fail_limit <= pwdata[7:0];
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      entry_count <= '0;
      pend_valid <= 1'b0;
      out_valid <= 1'b0;
      idx <= '0;
      slots <= '0;
    end else begin
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_acc) begin
            op <= kind;
            id_r <= frame_id;
            ext_r <= extended;
            per_r <= period_ms;
            now_r <= now_tick;
            idx <= '0;
            if (32'(free_slots) > TX_SLOTS) begin
              slots <= SW'(TX_SLOTS);
            end else begin
              slots <= SW'(free_slots);
            end
            case (kind)
              KIND_ADD: begin
                if (32'(entry_count) >= MAX_ENTRIES) begin
                  pend <= mk_status(ST_FULL);
                  pend_valid <= 1'b1;
                  state <= S_FIN;
                end else if (period_ms == 16'd0) begin
                  pend <= mk_status(ST_ZERO_PER);
                  pend_valid <= 1'b1;
                  state <= S_FIN;
                end else begin
                  state <= S_RD;
                end
              end
              KIND_REMOVE, KIND_PASS: state <= S_RD;
              default: state <= S_IDLE;
            endcase
          end
        end
        S_RD: begin
          if (idx == entry_count) begin
            case (op)
              KIND_ADD: state <= S_ADDWR;
              KIND_REMOVE: begin
                pend <= mk_status(ST_NOT_FOUND);
                pend_valid <= 1'b1;
                state <= S_FIN;
              end
              default: state <= S_FIN;
            endcase
          end else begin
            state <= S_CHK;
          end
        end
        S_CHK: begin
          ent <= ram_rdata;
          elapsed <= el_now;
          if (op == KIND_PASS) begin
            if (!due) begin
              idx <= idx + 1'b1;
              state <= S_RD;
            end else if (slots != '0) begin
              state <= S_SEND;
            end else begin
              state <= S_DIV;
            end
          end else if (ram_rdata.id == id_r) begin
            if (op == KIND_ADD) begin
              pend <= mk_status(ST_DUP);
              pend_valid <= 1'b1;
              state <= S_FIN;
            end else if (idx_p1 < cnt_x) begin
              state <= S_SHRD;
            end else begin
              entry_count <= entry_count - 1'b1;
              pend <= mk_status(ST_OK);
              pend_valid <= 1'b1;
              state <= S_FIN;
            end
          end else begin
            idx <= idx + 1'b1;
            state <= S_RD;
          end
        end
        S_SEND: begin
          slots <= slots - 1'b1;
          res <= rep;
          state <= S_PUSH;
        end
        S_DIV: begin
          if (div_done) begin
            state <= S_DEFER;
          end
        end
        S_DEFER: begin
          res <= rep;
          state <= S_PUSH;
        end
        S_PUSH: begin
          // the held result goes out once the next one is known
          if (out_free) begin
            if (pend_valid) begin
              out_r <= pend;
            end
            pend <= res;
            pend_valid <= 1'b1;
            idx <= idx + 1'b1;
            state <= S_RD;
          end
        end
        S_SHRD: state <= S_SHWR;
        S_SHWR: begin
          idx <= idx + 1'b1;
          if (idx_p2 < cnt_x) begin
            state <= S_SHRD;
          end else begin
            entry_count <= entry_count - 1'b1;
            pend <= mk_status(ST_OK);
            pend_valid <= 1'b1;
            state <= S_FIN;
          end
        end
        S_ADDWR: begin
          entry_count <= entry_count + 1'b1;
          pend <= mk_status(ST_OK);
          pend_valid <= 1'b1;
          state <= S_FIN;
        end
        S_FIN: begin
          if (!pend_valid) begin
            state <= S_IDLE;
          end else if (out_free) begin
            out_r <= pend_last;
            pend_valid <= 1'b0;
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign result_kind  = out_r.kind;
  assign status       = out_r.status;
  assign entry_index  = out_r.index;
  assign out_id       = out_r.id;
  assign out_extended = out_r.ext;
  assign sent         = out_r.sent;
  assign abort_all    = out_r.abort;
  assign last         = out_r.last;

  // checks
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    32'(entry_count) <= MAX_ENTRIES) else $error("entry count past table size");

  a_idle_no_pend: assert property (@(posedge clk) disable iff (rst)
    state == S_IDLE |-> !pend_valid) else $error("held result left behind");

  a_we_busy: assert property (@(posedge clk) disable iff (rst)
    ram_we |-> state != S_IDLE) else $error("table write while idle");

  a_slots_cap: assert property (@(posedge clk) disable iff (rst)
    32'(slots) <= TX_SLOTS) else $error("slot count above cap");

  a_out_before_push: assert property (@(posedge clk) disable iff (rst)
    state == S_PUSH && !out_free |=> state == S_PUSH) else $error("push ran over stalled output");

endmodule
